// ===== rtl/key_debounce_long_press_repeat_defines.svh =====
// ---------------------------------------------------------------------------
// Key debounce assertion macros
// Shared property macros; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define KDLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key debounce check failed");
// next-cycle implication
`define KDLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key debounce check failed");
`else
`define KDLP_ASSERT_NOW(label, clk, rst, ante, cons)
`define KDLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/kdlp_pkg.sv =====
// ---------------------------------------------------------------------------
// kdlp_pkg
// Types and constants of the key debounce / long press / repeat block.
// ---------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

   localparam int LEVELS_W = 4;   // key_levels field width
   localparam int MASK_W   = 4;   // repeat_key_mask width
   localparam int EVENT_W  = 3;   // key_event width
   localparam int SAME_W   = 8;   // same-level counter / debounce_ticks
   localparam int HOLD_W   = 16;  // hold counter / long and repeat ticks
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [SAME_W-1:0] SAME_MAX = {SAME_W{1'b1}};
   localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

   localparam logic [SAME_W-1:0] DEBOUNCE_RESET   = 8'd5;
   localparam logic [HOLD_W-1:0] LONG_START_RESET = 16'd100;
   localparam logic [HOLD_W-1:0] REPEAT_RESET     = 16'd10;
   localparam logic [MASK_W-1:0] KEY_MASK_RESET   = 4'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_LONG_START = 2'd1,
      CSR_REPEAT     = 2'd2,
      CSR_KEY_MASK   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SAME_W-1:0] debounce_ticks;
      logic [HOLD_W-1:0] long_start_ticks;
      logic [HOLD_W-1:0] repeat_ticks;
   } timing_type;

   typedef struct packed {
      logic fire;       // key reports this tick
      logic settled;    // settled level, 1 released
      logic repeating;  // long-press mode
   } key_status_type;

endpackage

`default_nettype wire

// ===== rtl/kdlp_key_cell.sv =====
// ---------------------------------------------------------------------------
// kdlp_key_cell
// State and one-tick update of a single key: debounce, hold, repeat.
// ---------------------------------------------------------------------------
`default_nettype none

module kdlp_key_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   level,
   input  wire logic                   can_rep,
   input  wire kdlp_pkg::timing_type     timing,
   output      kdlp_pkg::key_status_type status
);
   import kdlp_pkg::*;

   logic              sampled_ff, sampled_in;
   logic              settled_ff, settled_in;
   logic [SAME_W-1:0] same_ff, same_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              rep_ff, rep_in;
   logic              fire;

   logic [SAME_W-1:0] same_inc;
   logic [HOLD_W-1:0] hold_a, hold_b;
   logic              rep_a, settle;

   always_comb begin
      sampled_in = sampled_ff;
      settled_in = settled_ff;
      same_in    = same_ff;
      hold_in    = hold_ff;
      rep_in     = rep_ff;
      fire       = 1'b0;
      same_inc   = (same_ff == SAME_MAX) ? same_ff : same_ff + 1'b1;
      settle     = (same_inc == timing.debounce_ticks) && (level != settled_ff);
      hold_a     = settle ? '0 : hold_ff;
      rep_a      = settle ? 1'b0 : rep_ff;
      hold_b     = (hold_a == HOLD_MAX) ? hold_a : hold_a + 1'b1;

      if (level != sampled_ff) begin
         // sample change restarts both counters, mode kept
         sampled_in = level;
         same_in    = '0;
         hold_in    = '0;
      end else begin
         same_in = same_inc;
         hold_in = hold_a;
         rep_in  = rep_a;
         if (settle) begin
            settled_in = level;
            // short press on release, unless the press went long
            fire = level && !rep_ff;
         end
         if (!settled_in && (same_inc >= timing.debounce_ticks)) begin
            hold_in = hold_b;
            if (!rep_a) begin
               if (hold_b >= timing.long_start_ticks) begin
                  rep_in  = 1'b1;
                  hold_in = '0;
                  fire    = can_rep;
               end
            end else if (hold_b >= timing.repeat_ticks) begin
               hold_in = '0;
               fire    = can_rep;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff <= 1'b1;
         settled_ff <= 1'b1;
         same_ff    <= '0;
         hold_ff    <= '0;
         rep_ff     <= 1'b0;
      end else if (step) begin
         sampled_ff <= sampled_in;
         settled_ff <= settled_in;
         same_ff    <= same_in;
         hold_ff    <= hold_in;
         rep_ff     <= rep_in;
      end
   end

   assign status.fire      = fire;
   assign status.settled   = settled_ff;
   assign status.repeating = rep_ff;

endmodule

`default_nettype wire

// ===== rtl/key_debounce_long_press_repeat.sv =====
// ---------------------------------------------------------------------------
// key_debounce_long_press_repeat
// Debounces active-low keys; reports short press, long press and repeat.
// ---------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tdata: key_levels[3:0], repeat_enable[4]
//  rsp_     out  rsp_tvalid/tready    tdata: event_code[2:0]
//  csr_     in   csr_valid/ready      csr_index, csr_data (always ready)
//
//  One scan tick per clock while the result side keeps up. A tick is captured
//  in the input register, then all keys update in parallel and the event lands
//  in the result register, which drives rsp_tvalid. The per-key counter update
//  (8-bit increment/compare, then 16-bit increment/compare) sets the path.
//  With a result stalled, one more tick is held in the input register.
//  Synchronous reset: keys released, counters clear, configuration to defaults.
// ---------------------------------------------------------------------------
`default_nettype none

`include "key_debounce_long_press_repeat_defines.svh"

module key_debounce_long_press_repeat #(
   parameter int KEY_COUNT = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: key_levels[3:0], repeat_enable[4], zeros above
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [kdlp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tdata: event_code[2:0], zeros above
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [kdlp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [kdlp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kdlp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import kdlp_pkg::*;

   // configuration
   timing_type        timing_ff;
   logic [MASK_W-1:0] key_mask_ff;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [LEVELS_W-1:0] levels_ff;
   logic                rep_en_ff;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [EVENT_W-1:0] event_ff, event_in;

   logic                 advance, req_take;
   logic [KEY_COUNT-1:0] fire_vec, settled_vec, rep_vec;

   // ---- configuration writes (block idle by contract) ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.debounce_ticks   <= DEBOUNCE_RESET;
         timing_ff.long_start_ticks <= LONG_START_RESET;
         timing_ff.repeat_ticks     <= REPEAT_RESET;
         key_mask_ff                <= KEY_MASK_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   timing_ff.debounce_ticks   <= csr_data[SAME_W-1:0];
            CSR_LONG_START: timing_ff.long_start_ticks <= csr_data[HOLD_W-1:0];
            CSR_REPEAT:     timing_ff.repeat_ticks     <= csr_data[HOLD_W-1:0];
            CSR_KEY_MASK:   key_mask_ff                <= csr_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- two-register pipeline control ----
   // the captured tick moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         levels_ff <= req_tdata[LEVELS_W-1:0];
         rep_en_ff <= req_tdata[LEVELS_W];
      end
      if (advance) begin
         event_ff <= event_in;
      end
   end

   // ---- key cells; bits past the field widths read as zero ----
   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
      logic           lvl, mask_bit;
      key_status_type stat;

      if (k < LEVELS_W) begin : g_lvl
         assign lvl = levels_ff[k];
      end else begin : g_lvl_none
         assign lvl = 1'b0;
      end
      if (k < MASK_W) begin : g_mask
         assign mask_bit = key_mask_ff[k];
      end else begin : g_mask_none
         assign mask_bit = 1'b0;
      end

      kdlp_key_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .step    (advance),
         .level   (lvl),
         .can_rep (rep_en_ff && mask_bit),
         .timing  (timing_ff),
         .status  (stat)
      );

      assign fire_vec[k]    = stat.fire;
      assign settled_vec[k] = stat.settled;
      assign rep_vec[k]     = stat.repeating;
   end

   // lowest key wins; a key whose code wraps to zero cannot claim the tick
   always_comb begin
      event_in = '0;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (fire_vec[i] && (EVENT_W'(i + 1) != '0)) begin
            event_in = EVENT_W'(i + 1);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - EVENT_W){1'b0}}, event_ff};

   // ---- checks ----
   // a held tick must not be overwritten while the result is stalled
   `KDLP_ASSERT_NOW(a_no_overrun, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_tready, !req_tready)
   // long-press mode only exists on a settled-pressed key
   `KDLP_ASSERT_NOW(a_rep_pressed, clock, reset, 1'b1, (rep_vec & settled_vec) == '0)
   // an accepted tick is held or already passed on at the next edge
   `KDLP_ASSERT_NEXT(a_tick_held, clock, reset, req_take, in_valid_ff || out_valid_ff)

endmodule

`default_nettype wire

// ===== bench/key_debounce_long_press_repeat_tb.sv =====
// ---------------------------------------------------------------------------
// key_debounce_long_press_repeat_tb
// Self-checking bench for the key debouncer: a scan-tick stream goes in, one
// key event per tick comes out and is compared with an in-bench model of the
// debounce, long-press and repeat counters. A short directed table runs
// first. Random key sequences follow, under several register settings, with
// random idling on both channels and one long hold-off on the result side.
// ---------------------------------------------------------------------------
`default_nettype none

module key_debounce_long_press_repeat_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kdlp_pkg::*;

   localparam int KEYS           = LEVELS_W;
   localparam int STALL_LIMIT    = 1000;  // quiet cycles before the watchdog trips
   localparam int HOLD_OFF_TICKS = 60;    // long result-side hold-off
   localparam int RESET_ROWS     = 4;     // directed rows run at reset settings
   localparam int DIRECTED_ROWS  = 25;

   localparam logic [EVENT_W-1:0] NO_EVENT = '0;

   // ------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value
   // ------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // key_levels[3:0], repeat_enable[4]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // event_code[2:0]
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   key_debounce_long_press_repeat #(
      .KEY_COUNT (KEYS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------
   // Model state: register copies and per-key debounce counters
   // ------------------------------------------------------------------
   logic [SAME_W-1:0] cfg_debounce   = DEBOUNCE_RESET;
   logic [HOLD_W-1:0] cfg_long_start = LONG_START_RESET;
   logic [HOLD_W-1:0] cfg_repeat     = REPEAT_RESET;
   logic [MASK_W-1:0] cfg_key_mask   = KEY_MASK_RESET;

   logic              sampled_lvl [KEYS] = '{default: 1'b1};
   logic              settled_lvl [KEYS] = '{default: 1'b1};
   logic [SAME_W-1:0] same_cnt    [KEYS] = '{default: '0};
   logic [HOLD_W-1:0] hold_cnt    [KEYS] = '{default: '0};
   logic              held_long   [KEYS] = '{default: 1'b0};

   logic [RSP_DATA_W-1:0] expected_events [$];
   int                    mismatches = 0;

   // Bench controls shared between the sender and the receiver
   logic stalls_on        = 1'b1;
   logic hold_off_request = 1'b0;

   // One scan tick through the model; returns the key event it reports.
   function automatic logic [EVENT_W-1:0] predict_event(
      input logic [LEVELS_W-1:0] levels,
      input logic                rep_en
   );
      logic [EVENT_W-1:0] ev;
      logic [EVENT_W-1:0] code;
      logic               lvl;
      logic               can_rep;
      ev = NO_EVENT;
      for (int k = 0; k < KEYS; k++) begin
         lvl     = levels[k];
         can_rep = rep_en && cfg_key_mask[k];
         code    = EVENT_W'(k + 1);
         // a change of sample restarts both counts; long mode is kept
         if (lvl != sampled_lvl[k]) begin
            sampled_lvl[k] = lvl;
            same_cnt[k]    = '0;
            hold_cnt[k]    = '0;
            continue;
         end
         if (same_cnt[k] != SAME_MAX)
            same_cnt[k] = same_cnt[k] + 1'b1;
         // newly settled level; a release outside long mode is a short press
         if (same_cnt[k] == cfg_debounce && lvl != settled_lvl[k]) begin
            settled_lvl[k] = lvl;
            if (lvl && !held_long[k] && ev == NO_EVENT)
               ev = code;
            hold_cnt[k]  = '0;
            held_long[k] = 1'b0;
         end
         // settled and held: long-press entry, then periodic repeats
         if (!settled_lvl[k] && same_cnt[k] >= cfg_debounce) begin
            if (hold_cnt[k] != HOLD_MAX)
               hold_cnt[k] = hold_cnt[k] + 1'b1;
            if (!held_long[k]) begin
               if (hold_cnt[k] >= cfg_long_start) begin
                  held_long[k] = 1'b1;
                  hold_cnt[k]  = '0;
                  if (can_rep && ev == NO_EVENT)
                     ev = code;
               end
            end else if (hold_cnt[k] >= cfg_repeat) begin
               hold_cnt[k] = '0;
               if (can_rep && ev == NO_EVENT)
                  ev = code;
            end
         end
      end
      return ev;
   endfunction

   task automatic note_mismatch(input string what, input logic [RSP_DATA_W-1:0] want,
                                input logic [RSP_DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d: %s, expected %0d, got %0d", mismatches, what, want, got);
   endtask

   // ------------------------------------------------------------------
   // Sender: one scan tick per transaction; model runs at acceptance.
   // A typed expectation replaces the model's answer in the queue.
   // ------------------------------------------------------------------
   task automatic send_scan(input logic [LEVELS_W-1:0] levels, input logic rep_en,
                            input logic typed = 1'b0,
                            input logic [EVENT_W-1:0] typed_event = NO_EVENT);
      logic [EVENT_W-1:0] ev;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({rep_en, levels});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ev = predict_event(levels, rep_en);
      expected_events.push_back(RSP_DATA_W'(typed ? typed_event : ev));
      // occasional idle gap before the next offer
      if (stalls_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   // Quiesce: stop offering and let every result drain, then pause
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   // All four registers in one back-to-back burst; valid stays high between
   task automatic write_config(input logic [SAME_W-1:0] debounce,
                               input logic [HOLD_W-1:0] long_start,
                               input logic [HOLD_W-1:0] repeat_gap,
                               input logic [MASK_W-1:0] key_mask);
      csr_index_type order [4] = '{CSR_DEBOUNCE, CSR_LONG_START, CSR_REPEAT, CSR_KEY_MASK};
      logic [CSR_DATA_W-1:0] value;
      for (int r = 0; r < 4; r++) begin
         case (order[r])
            CSR_DEBOUNCE:   value = CSR_DATA_W'(debounce);
            CSR_LONG_START: value = long_start;
            CSR_REPEAT:     value = repeat_gap;
            default:        value = CSR_DATA_W'(key_mask);
         endcase
         csr_valid <= 1'b1;
         csr_index <= order[r];
         csr_data  <= value;
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         case (order[r])
            CSR_DEBOUNCE:   cfg_debounce   = value[SAME_W-1:0];
            CSR_LONG_START: cfg_long_start = value[HOLD_W-1:0];
            CSR_REPEAT:     cfg_repeat     = value[HOLD_W-1:0];
            default:        cfg_key_mask   = value[MASK_W-1:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Random key activity: each key holds its level and flips now and then;
   // some ticks carry bounce noise on top. toggle_odds and noise_odds are
   // "one in N"; a noise_odds of 0 gives clean levels.
   task automatic run_random(input int count, input int toggle_odds, input int noise_odds);
      logic [LEVELS_W-1:0] held;
      logic                rep_en;
      held   = LEVELS_W'($urandom);
      rep_en = 1'b1;
      repeat (count) begin
         for (int k = 0; k < KEYS; k++)
            if ($urandom_range(1, toggle_odds) == 1)
               held[k] = ~held[k];
         if ($urandom_range(0, 39) == 0)
            rep_en = ~rep_en;
         if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
            send_scan(held ^ LEVELS_W'($urandom_range(1, 15)), rep_en);
         else
            send_scan(held, rep_en);
      end
   endtask

   // ------------------------------------------------------------------
   // Directed table. Rows marked typed carry an expectation that is
   // obvious by inspection; the rest are checked against the model.
   // ------------------------------------------------------------------
   typedef struct {
      logic [LEVELS_W-1:0] levels;
      logic                rep_en;
      logic                typed;
      logic [EVENT_W-1:0]  event_code;
   } scan_row_type;

   scan_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset settings: all released, then a one-tick glitch, no report
      '{4'hF, 1'b0, 1'b1, NO_EVENT},
      '{4'hF, 1'b1, 1'b1, NO_EVENT},
      '{4'h0, 1'b1, 1'b1, NO_EVENT},
      '{4'hF, 1'b1, 1'b1, NO_EVENT},
      // minimum debounce, short long-press and repeat, all keys may repeat:
      // all pressed; lowest key wins the long press and each repeat
      '{4'h0, 1'b1, 1'b0, NO_EVENT},
      '{4'h0, 1'b1, 1'b0, NO_EVENT},
      '{4'h0, 1'b1, 1'b0, NO_EVENT},
      '{4'h0, 1'b1, 1'b0, NO_EVENT},
      // release after long mode: no short press
      '{4'hF, 1'b1, 1'b0, NO_EVENT},
      '{4'hF, 1'b1, 1'b0, NO_EVENT},
      '{4'hF, 1'b1, 1'b0, NO_EVENT},
      // keys 0 and 2 held with repeat disabled: long mode but silent
      '{4'hA, 1'b0, 1'b0, NO_EVENT},
      '{4'hA, 1'b0, 1'b0, NO_EVENT},
      '{4'hA, 1'b0, 1'b0, NO_EVENT},
      '{4'hA, 1'b0, 1'b0, NO_EVENT},
      // ... and their release stays silent as well
      '{4'hF, 1'b0, 1'b0, NO_EVENT},
      '{4'hF, 1'b0, 1'b0, NO_EVENT},
      '{4'hF, 1'b0, 1'b0, NO_EVENT},
      // brief press of key 3: short press on release
      '{4'h7, 1'b1, 1'b0, NO_EVENT},
      '{4'h7, 1'b1, 1'b0, NO_EVENT},
      '{4'hF, 1'b1, 1'b0, NO_EVENT},
      '{4'hF, 1'b1, 1'b0, NO_EVENT},
      '{4'hF, 1'b1, 1'b0, NO_EVENT},
      // every sample changes: counters keep restarting
      '{4'h5, 1'b1, 1'b0, NO_EVENT},
      '{4'hA, 1'b0, 1'b0, NO_EVENT}
   };

   // ------------------------------------------------------------------
   // Result checker: every accepted result against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0)
            note_mismatch("event code with nothing outstanding", '0, rsp_tdata);
         else if (rsp_tdata !== expected_events[0]) begin
            note_mismatch("event code", expected_events[0], rsp_tdata);
            void'(expected_events.pop_front());
         end else
            void'(expected_events.pop_front());
      end
   end

   // ------------------------------------------------------------------
   // Receiver: short random stalls, plus one long hold-off on request so
   // that the block fills up and pushes back on the scan input
   // ------------------------------------------------------------------
   initial begin : receiver
      bit hold_off_done;
      hold_off_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_TICKS - 1)
               @(posedge clock);
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2))
               @(posedge clock);
         end else
            rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transaction on any channel
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      repeat (2)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; settings change once the reset-value rows are done
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (r == RESET_ROWS) begin
            settle_idle();
            write_config(8'd1, 16'd2, 16'd1, 4'hF);
         end
         send_scan(directed_rows[r].levels, directed_rows[r].rep_en,
                   directed_rows[r].typed, directed_rows[r].event_code);
      end

      // zero debounce: nothing ever settles
      settle_idle();
      write_config(8'd0, 16'd0, 16'd0, 4'hF);
      run_random(60, 8, 10);

      // zero long-start and repeat: long mode at once, then a report every tick
      settle_idle();
      write_config(8'd1, 16'd0, 16'd0, 4'hA);
      run_random(80, 10, 12);

      // top of every range, clean levels so the same-level count saturates
      settle_idle();
      write_config(SAME_MAX, HOLD_MAX, HOLD_MAX, 4'h0);
      run_random(320, 400, 0);

      // back to the reset settings
      settle_idle();
      write_config(DEBOUNCE_RESET, LONG_START_RESET, REPEAT_RESET, KEY_MASK_RESET);
      run_random(300, 150, 40);

      // small random settings, where long press and repeat come often
      for (int p = 0; p < 4; p++) begin
         settle_idle();
         write_config(SAME_W'($urandom_range(1, 6)), HOLD_W'($urandom_range(1, 24)),
                      HOLD_W'($urandom_range(1, 8)), MASK_W'($urandom));
         if (p == 1)
            hold_off_request = 1'b1;
         run_random(200, 40, 15);
      end

      // closing stretch at full rate, no idling on either side
      settle_idle();
      write_config(SAME_W'($urandom_range(1, 4)), HOLD_W'($urandom_range(1, 12)),
                   HOLD_W'($urandom_range(1, 4)), MASK_W'($urandom));
      stalls_on = 1'b0;
      run_random(250, 30, 15);

      settle_idle();
      repeat (4)
         @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
